// ----- rtl/ksel_pkg.sv -----
// ksel_pkg: beat types, command type and fixed widths for the k-smallest selection unit
// no dependencies; used by every file of the unit
`default_nettype none

package ksel_pkg;

    localparam int VALUE_W = 32;
    localparam int SLOT_FIELD_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] new_value;
        logic signed [VALUE_W-1:0] new_index;
        logic [SLOT_FIELD_W-1:0]   read_slot;
    } in_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] slot_value;
        logic signed [VALUE_W-1:0] slot_index;
        logic                      slot_valid;
        logic [COUNT_W-1:0]        filled_count;
    } out_beat_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] tag;
        logic [SLOT_FIELD_W-1:0]   slot;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ksel_front.sv -----
// ksel_front: accepts input beats, decodes the request type and queues commands
// depends on ksel_pkg
`default_nettype none

module ksel_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire ksel_pkg::in_beat_t item,
    output logic                  cmd_valid,
    output ksel_pkg::cmd_t        cmd,
    input  wire logic             cmd_take
);

    ksel_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_wr;
    logic           do_rd;
    ksel_pkg::cmd_t decoded;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_take && cmd_valid;

    always_comb
    begin
        decoded.op    = item.req_type ? ksel_pkg::OP_READ : ksel_pkg::OP_PUSH;
        decoded.value = item.new_value;
        decoded.tag   = item.new_index;
        decoded.slot  = item.read_slot;
    end

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ksel_back.sv -----
// ksel_back: slot store, max scan sequencer and result buffer
// depends on ksel_pkg
`default_nettype none

module ksel_back
#(
    parameter int KEEP_COUNT = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire ksel_pkg::cmd_t    cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  wire logic              pop,
    output ksel_pkg::out_beat_t    result
);

    localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int FILL_W = $clog2(KEEP_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    logic signed [ksel_pkg::VALUE_W-1:0] val_mem [KEEP_COUNT];
    logic signed [ksel_pkg::VALUE_W-1:0] tag_mem [KEEP_COUNT];
    logic signed [ksel_pkg::VALUE_W-1:0] rd_val_reg;
    logic signed [ksel_pkg::VALUE_W-1:0] rd_tag_reg;
    logic [SLOT_W-1:0]                   rd_addr;
    logic                                we;
    logic [SLOT_W-1:0]                   wr_addr;
    logic signed [ksel_pkg::VALUE_W-1:0] wr_val;
    logic signed [ksel_pkg::VALUE_W-1:0] wr_tag;

    state_t                              state_reg;
    state_t                              state_next;
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic [SLOT_W-1:0]                   scan_idx_reg;
    logic [SLOT_W-1:0]                   scan_idx_next;
    logic signed [ksel_pkg::VALUE_W-1:0] best_val_reg;
    logic signed [ksel_pkg::VALUE_W-1:0] best_val_next;
    logic [SLOT_W-1:0]                   best_slot_reg;
    logic [SLOT_W-1:0]                   best_slot_next;
    logic signed [ksel_pkg::VALUE_W-1:0] cur_val_reg;
    logic signed [ksel_pkg::VALUE_W-1:0] cur_val_next;
    logic signed [ksel_pkg::VALUE_W-1:0] cur_tag_reg;
    logic signed [ksel_pkg::VALUE_W-1:0] cur_tag_next;
    logic                                res_valid_reg;
    logic                                res_valid_next;
    ksel_pkg::out_beat_t                 res_reg;
    ksel_pkg::out_beat_t                 res_next;

    logic                                store_full;
    logic                                slot_hit;
    logic                                scan_last;
    logic [ksel_pkg::COUNT_W-1:0]        fill_ext;

    assign empty      = !res_valid_reg;
    assign result     = res_reg;
    assign store_full = (fill_reg == FILL_W'(KEEP_COUNT));
    assign fill_ext   = ksel_pkg::COUNT_W'(fill_reg);
    assign slot_hit   = (ksel_pkg::COUNT_W'(cmd.slot) < fill_ext);
    assign scan_last  = (scan_idx_reg == SLOT_W'(KEEP_COUNT - 1));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        best_val_next  = best_val_reg;
        best_slot_next = best_slot_reg;
        cur_val_next   = cur_val_reg;
        cur_tag_next   = cur_tag_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        cmd_take       = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wr_addr        = fill_reg[SLOT_W-1:0];
        wr_val         = cmd.value;
        wr_tag         = cmd.tag;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == ksel_pkg::OP_READ)
                    begin
                        // read waits until the result buffer is free
                        if (!res_valid_reg)
                        begin
                            cmd_take = 1'b1;
                            if (slot_hit)
                            begin
                                rd_addr    = cmd.slot[SLOT_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_next.slot_value   = '0;
                                res_next.slot_index   = '0;
                                res_next.slot_valid   = 1'b0;
                                res_next.filled_count = fill_ext;
                                res_valid_next        = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        if (!store_full)
                        begin
                            // append at the fill point
                            we        = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            cur_val_next  = cmd.value;
                            cur_tag_next  = cmd.tag;
                            rd_addr       = '0;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_next.slot_value   = rd_val_reg;
                res_next.slot_index   = rd_tag_reg;
                res_next.slot_valid   = 1'b1;
                res_next.filled_count = fill_ext;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_SCAN:
            begin
                // strict greater keeps the lowest slot on a tie
                if ((scan_idx_reg == '0) || (rd_val_reg > best_val_reg))
                begin
                    best_val_next  = rd_val_reg;
                    best_slot_next = scan_idx_reg;
                end
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    rd_addr       = scan_idx_reg + 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (best_val_reg > cur_val_reg)
                begin
                    we      = 1'b1;
                    wr_addr = best_slot_reg;
                    wr_val  = cur_val_reg;
                    wr_tag  = cur_tag_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        best_val_reg  <= best_val_next;
        best_slot_reg <= best_slot_next;
        cur_val_reg   <= cur_val_next;
        cur_tag_reg   <= cur_tag_next;
        res_reg       <= res_next;
    end

    // slot store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            val_mem[wr_addr] <= wr_val;
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_val_reg <= val_mem[rd_addr];
        rd_tag_reg <= tag_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/keep_k_smallest_with_index_unit.sv -----
// keep_k_smallest_with_index_unit: top level of the streaming k-smallest selection unit
// depends on ksel_pkg, ksel_front and ksel_back
//
// usage
//   input channel: a beat is taken at a rising edge with push high and full low;
//   req_type 0 offers a candidate value with its index, req_type 1 reads one slot
//   result channel: one beat per read, none per push; the oldest result sits on
//   result while empty is low and leaves at an edge with pop high
// timing
//   a two-entry command queue sits in front of the store sequencer, so up to two
//   beats are taken while the sequencer is busy
//   read: a filled slot passes the READ state for the registered store read, an
//   unfilled slot is answered from IDLE; either way the result is registered
//   push while filling: written at the fill point straight from IDLE
//   push on a full store: a max scan that reads one slot per cycle from the
//   single store read port, then the UPDATE state
// reset
//   rst_n clears the fill count, the queue and the result buffer; the store
//   contents are left as they are and only filled slots are ever read
// stall
//   while a result waits unpopped, a following read holds at the head of the
//   queue and every beat behind it waits too; full rises once the queue holds
//   two beats
`default_nettype none

module keep_k_smallest_with_index_unit
#(
    parameter int KEEP_COUNT = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ksel_pkg::in_beat_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output ksel_pkg::out_beat_t      result
);

    // command path between front and back
    logic           cmd_valid;
    logic           cmd_take;
    ksel_pkg::cmd_t cmd;

    ksel_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    ksel_back
    #(
        .KEEP_COUNT (KEEP_COUNT)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- rtl/ksel_checker.sv -----
// ksel_checker: port level checks on the k-smallest selection unit, with its bind
// depends on ksel_pkg and keep_k_smallest_with_index_unit
`default_nettype none

module ksel_checker
#(
    parameter int KEEP_COUNT = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire ksel_pkg::out_beat_t result
);

    // fill count never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.filled_count <= ksel_pkg::COUNT_W'(KEEP_COUNT)))
        else $error("filled_count above store size");

    // an unfilled slot reads as zeros
    a_unfilled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.slot_valid) |->
            (result.slot_value == '0 && result.slot_index == '0))
        else $error("unfilled slot returned data");

    // a valid slot implies a nonzero fill
    a_valid_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.slot_valid) |-> (result.filled_count != '0))
        else $error("valid slot with empty store");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed before pop");

endmodule

bind keep_k_smallest_with_index_unit ksel_checker
#(
    .KEEP_COUNT (KEEP_COUNT)
)
u_ksel_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// ----- test/keep_k_smallest_with_index_unit_test.sv -----
// keep_k_smallest_with_index_unit_test: self-checking bench for the k-smallest selection unit
// a directed table and then random beats, with results checked against a shadow store
// depends on ksel_pkg and keep_k_smallest_with_index_unit
`timescale 1ns / 100ps

module keep_k_smallest_with_index_unit_test;

    localparam int KEEP = 8;
    localparam int RANDOM_BEATS = 1350;
    localparam int CYCLE_LIMIT = 1000000;

    // one row of the directed table; fixed_want marks rows whose read result is typed in
    typedef struct packed {
        ksel_pkg::op_t                       op;
        logic signed [ksel_pkg::VALUE_W-1:0] value;
        logic signed [ksel_pkg::VALUE_W-1:0] tag;
        logic [ksel_pkg::SLOT_FIELD_W-1:0]   slot;
        logic                                fixed_want;
        ksel_pkg::out_beat_t                 want;
    } table_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                pop = 1'b0;
    ksel_pkg::in_beat_t  item = '0;
    logic                full;
    logic                empty;
    ksel_pkg::out_beat_t result;

    // shadow copy of the store, updated in the order beats are taken
    logic signed [ksel_pkg::VALUE_W-1:0] shadow_values [KEEP];
    logic signed [ksel_pkg::VALUE_W-1:0] shadow_tags [KEEP];
    int                                  shadow_fill = 0;

    // read results still owed by the unit, oldest first
    ksel_pkg::out_beat_t pending_reads [$];
    table_row_t          directed_rows [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    keep_k_smallest_with_index_unit #(
        .KEEP_COUNT(KEEP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // single reset pulse at the start of the run
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idle length shared by both sides: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // applies one taken beat to the shadow store; a read yields the expected result
    function automatic void step_shadow_store(input ksel_pkg::in_beat_t beat,
                                              output logic gives_read,
                                              output ksel_pkg::out_beat_t read_out);
        int peak_slot;
        gives_read = 1'b0;
        read_out = '0;
        if (ksel_pkg::op_t'(beat.req_type) == ksel_pkg::OP_PUSH)
        begin
            if (shadow_fill < KEEP)
            begin
                // still filling: append at the next free slot
                shadow_values[shadow_fill] = beat.new_value;
                shadow_tags[shadow_fill] = beat.new_index;
                shadow_fill++;
            end
            else
            begin
                // strict compare keeps the lowest slot among equal maxima
                peak_slot = 0;
                for (int s = 1; s < KEEP; s++)
                    if (shadow_values[s] > shadow_values[peak_slot])
                        peak_slot = s;
                // a candidate equal to the maximum is dropped
                if (beat.new_value < shadow_values[peak_slot])
                begin
                    shadow_values[peak_slot] = beat.new_value;
                    shadow_tags[peak_slot] = beat.new_index;
                end
            end
        end
        else
        begin
            gives_read = 1'b1;
            // unfilled slots and slots past the store read as zero with valid low
            if (beat.read_slot < shadow_fill)
            begin
                read_out.slot_value = shadow_values[beat.read_slot];
                read_out.slot_index = shadow_tags[beat.read_slot];
                read_out.slot_valid = 1'b1;
            end
            read_out.filled_count = ksel_pkg::COUNT_W'(shadow_fill);
        end
    endfunction

    function automatic void add_row(ksel_pkg::op_t op,
                                    logic [ksel_pkg::VALUE_W-1:0] value,
                                    logic [ksel_pkg::VALUE_W-1:0] tag,
                                    logic [ksel_pkg::SLOT_FIELD_W-1:0] slot,
                                    logic fixed_want = 1'b0,
                                    logic [ksel_pkg::VALUE_W-1:0] want_value = '0,
                                    logic [ksel_pkg::VALUE_W-1:0] want_index = '0,
                                    logic want_valid = 1'b0,
                                    logic [ksel_pkg::COUNT_W-1:0] want_count = '0);
        table_row_t row;
        row.op = op;
        row.value = value;
        row.tag = tag;
        row.slot = slot;
        row.fixed_want = fixed_want;
        row.want.slot_value = want_value;
        row.want.slot_index = want_index;
        row.want.slot_valid = want_valid;
        row.want.filled_count = want_count;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // offers one beat and returns at the edge that takes it; push stays high afterwards
    task automatic send_beat(input ksel_pkg::in_beat_t beat, input logic fixed_want,
                             input ksel_pkg::out_beat_t want);
        logic                gives_read;
        ksel_pkg::out_beat_t read_out;
        item <= beat;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        step_shadow_store(beat, gives_read, read_out);
        if (gives_read)
            pending_reads.insert(pending_reads.size(), fixed_want ? want : read_out);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic void check_field(input string field,
                                        input logic [ksel_pkg::VALUE_W-1:0] want,
                                        input logic [ksel_pkg::VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: every taken beat is held against the oldest owed read
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t ns: result beat with none expected, actual %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                ksel_pkg::out_beat_t want;
                want = pending_reads.pop_front();
                check_field("slot_value", want.slot_value, result.slot_value);
                check_field("slot_index", want.slot_index, result.slot_index);
                check_field("slot_valid", ksel_pkg::VALUE_W'(want.slot_valid),
                            ksel_pkg::VALUE_W'(result.slot_valid));
                check_field("filled_count", ksel_pkg::VALUE_W'(want.filled_count),
                            ksel_pkg::VALUE_W'(result.filled_count));
            end
        end
    end

    // receiver: runs of pop high broken by stalls of random length
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            pop <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? 150 : $urandom_range(1, 24)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // run limit, far above the slowest legal run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("keep_k_smallest_with_index_unit verification failed");
        $finish;
    end

    // sender: directed table, then random beats, then drain
    initial
    begin
        ksel_pkg::in_beat_t                  beat;
        logic signed [ksel_pkg::VALUE_W-1:0] peak;
        int                                  no_gap_left;

        // empty store
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd0, 1'b1, 32'h0, 32'h0, 1'b0, 7'd0);
        add_row(ksel_pkg::OP_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1'b1,
                32'h0, 32'h0, 1'b0, 7'd0);
        // fill with the field extremes, read back while filling
        add_row(ksel_pkg::OP_PUSH, 32'h7FFFFFFF, 32'h80000000, 6'd63);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd0, 1'b1,
                32'h7FFFFFFF, 32'h80000000, 1'b1, 7'd1);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd1, 1'b1, 32'h0, 32'h0, 1'b0, 7'd1);
        add_row(ksel_pkg::OP_PUSH, 32'h80000000, 32'h7FFFFFFF, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'h0, 32'hFFFFFFFF, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'hFFFFFFFF, 32'h1, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'h5, 32'h2, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'h5, 32'h3, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd5, 1'b1, 32'h5, 32'h3, 1'b1, 7'd6);
        add_row(ksel_pkg::OP_PUSH, 32'd100, 32'h4, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'h7FFFFFFF, 32'h5, 6'd0);
        // store now full; last slot, first slot past the store, highest slot number
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd7, 1'b1, 32'h7FFFFFFF, 32'h5, 1'b1, 7'd8);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd8, 1'b1, 32'h0, 32'h0, 1'b0, 7'd8);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd63, 1'b1, 32'h0, 32'h0, 1'b0, 7'd8);
        // a candidate equal to the maximum leaves the store as it was
        add_row(ksel_pkg::OP_PUSH, 32'h7FFFFFFF, 32'h6, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd0, 1'b1,
                32'h7FFFFFFF, 32'h80000000, 1'b1, 7'd8);
        // tied maxima in slots 0 and 7: lowest slot is replaced first
        add_row(ksel_pkg::OP_PUSH, 32'h7FFFFFFE, 32'h7, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd0);
        add_row(ksel_pkg::OP_PUSH, 32'h7FFFFFFE, 32'h8, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd7);
        add_row(ksel_pkg::OP_PUSH, 32'h80000000, 32'h9, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd0);
        add_row(ksel_pkg::OP_READ, 32'h0, 32'h0, 6'd1);

        while (!rst_n)
            @(posedge clk);

        foreach (directed_rows[r])
        begin
            beat.req_type = directed_rows[r].op;
            beat.new_value = directed_rows[r].value;
            beat.new_index = directed_rows[r].tag;
            beat.read_slot = directed_rows[r].slot;
            send_beat(beat, directed_rows[r].fixed_want, directed_rows[r].want);
            idle_sender(pick_gap());
        end

        no_gap_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // now and then hold off until every owed read has come back
            if (n % 450 == 225)
            begin
                push <= 1'b0;
                do
                    @(posedge clk);
                while (pending_reads.size() != 0);
            end

            // ignored fields carry random bits too
            beat.new_value = $urandom;
            beat.new_index = $urandom;
            beat.read_slot = ksel_pkg::SLOT_FIELD_W'($urandom);
            if ($urandom_range(0, 99) < 55)
            begin
                beat.req_type = ksel_pkg::OP_PUSH;
                peak = shadow_values[0];
                for (int s = 1; s < shadow_fill; s++)
                    if (shadow_values[s] > peak)
                        peak = shadow_values[s];
                // steer candidates around the current maximum to hit replace and drop
                case ($urandom_range(0, 9))
                    4, 5: beat.new_value = $urandom_range(0, 40) - 20;
                    6: beat.new_value = peak;
                    7: beat.new_value = peak - $urandom_range(1, 3);
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0: beat.new_value = 32'h7FFFFFFF;
                            1: beat.new_value = 32'h80000000;
                            2: beat.new_value = 32'h0;
                            default: beat.new_value = 32'hFFFFFFFF;
                        endcase
                    end
                    9: beat.new_value = peak + 1;
                    default: ;
                endcase
            end
            else
            begin
                beat.req_type = ksel_pkg::OP_READ;
                if ($urandom_range(0, 9) < 8)
                    beat.read_slot = ksel_pkg::SLOT_FIELD_W'($urandom_range(0, KEEP));
            end
            send_beat(beat, 1'b0, '0);

            // stretches of back-to-back beats between random gaps
            if (no_gap_left > 0)
                no_gap_left--;
            else if ($urandom_range(0, 39) == 0)
                no_gap_left = $urandom_range(20, 60);
            else
                idle_sender(pick_gap());
        end

        // drain, then watch a while longer for stray result beats
        push <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (4 * KEEP) @(posedge clk);
        if (mismatch_count == 0)
            $display("keep_k_smallest_with_index_unit verification clean");
        else
            $display("keep_k_smallest_with_index_unit verification failed");
        $finish;
    end

endmodule
